// ----- src/udpck_pkg.sv -----
// Shared types and constants for the UDP/IPv4 length and checksum generator.
// Used by udpck_front, udpck_queue, udpck_back and udp_ipv4_checksum_fields.
// No dependencies.
package udpck_pkg;

    // Payload byte counter width, enough for the largest allowed payload
    localparam int CNT_W = 11;

    // Depth of the queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    // Fixed IPv4 header words
    localparam logic [15:0] IP_VER_IHL_WORD = 16'h4500;
    localparam logic [15:0] IP_FLAGS_DF     = 16'h4000;
    localparam logic [15:0] IP_TTL_PROTO    = 16'h4011;
    localparam logic [15:0] UDP_PROTO_WORD  = 16'h0011;
    localparam logic [16:0] IP_FIXED_SUM    =
        {1'b0, IP_VER_IHL_WORD} + {1'b0, IP_FLAGS_DF} + {1'b0, IP_TTL_PROTO};

    // Header sizes added to the payload count
    localparam logic [15:0] IP_UDP_HDR_BYTES = 16'd28;
    localparam logic [15:0] UDP_HDR_BYTES    = 16'd8;

    localparam logic [15:0] WORD_ONES = 16'hffff;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_SOURCE_IP   = 2'd0,
        CFG_DEST_IP     = 2'd1,
        CFG_SOURCE_PORT = 2'd2,
        CFG_DEST_PORT   = 2'd3
    } cfg_idx_t;

    // Configuration values seen by the back end
    typedef struct packed {
        logic [31:0] source_ip;
        logic [31:0] dest_ip_addr;
        logic [15:0] source_port;
        logic [15:0] dest_port;
    } cfg_t;

    // One finished datagram as handed from front to back
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             err;
        logic [15:0]      payload_sum;
    } rec_t;

    // First back-end stage: partial sums
    typedef struct packed {
        logic [17:0] ip_a;
        logic [16:0] ip_b;
        logic [17:0] udp_a;
        logic [18:0] udp_b;
        logic [15:0] ip_len;
        logic [15:0] udp_len;
        logic        err;
    } stage1_t;

    // Second back-end stage: full unfolded sums
    typedef struct packed {
        logic [18:0] ip_tot;
        logic [19:0] udp_tot;
        logic [15:0] ip_len;
        logic [15:0] udp_len;
        logic        err;
    } stage2_t;

    // Result transaction
    typedef struct packed {
        logic [15:0] ip_total_length;
        logic [15:0] ip_header_checksum;
        logic [15:0] udp_length;
        logic [15:0] udp_checksum;
        logic        length_error;
    } result_t;

endpackage

// ----- src/udpck_front.sv -----
// Front end: pairs payload bytes into words and keeps the running ones'-complement sum.
// On the last byte it emits one datagram record. Depends on udpck_pkg.
module udpck_front #(
    parameter int MaxPayload = 1472
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           payload_byte,
    input  logic                 payload_last,
    output logic                 rec_valid,
    output udpck_pkg::rec_t      rec
);
    import udpck_pkg::*;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MaxPayload);

    logic [15:0]      sum_reg, sum_next, sum_upd;
    logic [7:0]       held_reg, held_next, held_upd;
    logic [CNT_W-1:0] cnt_reg, cnt_next, cnt_upd;
    logic             ovf_reg, ovf_next, ovf_upd;
    logic [16:0]      sum_add;

    // Per-byte update of the datagram state
    always_comb
    begin
        sum_add = {1'b0, sum_reg} + {1'b0, held_reg, payload_byte};
        sum_upd = sum_reg;
        held_upd = held_reg;
        cnt_upd = cnt_reg;
        ovf_upd = ovf_reg;
        if (cnt_reg >= MAX_CNT)
        begin
            ovf_upd = 1'b1;
        end
        else
        begin
            if (!cnt_reg[0])
            begin
                held_upd = payload_byte;
            end
            else
            begin
                // end-around carry
                sum_upd = sum_add[15:0] + {15'd0, sum_add[16]};
            end
            cnt_upd = cnt_reg + CNT_W'(1);
        end
    end

    // Clear on the last byte, otherwise keep the update
    always_comb
    begin
        sum_next = sum_reg;
        held_next = held_reg;
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        if (accept)
        begin
            if (payload_last)
            begin
                sum_next = '0;
                held_next = '0;
                cnt_next = '0;
                ovf_next = 1'b0;
            end
            else
            begin
                sum_next = sum_upd;
                held_next = held_upd;
                cnt_next = cnt_upd;
                ovf_next = ovf_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            held_reg <= '0;
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            sum_reg <= sum_next;
            held_reg <= held_next;
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
        end
    end

    // Datagram record
    assign rec_valid = accept && payload_last;
    assign rec.count = cnt_upd;
    assign rec.err = ovf_upd || cnt_upd[0];
    assign rec.payload_sum = sum_upd;

    // Count saturates at the maximum payload
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= MAX_CNT)
        else $error("byte count above maximum payload");

endmodule

// ----- src/udpck_queue.sv -----
// Short queue of datagram records between front and back.
// Depends on udpck_pkg.
module udpck_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  udpck_pkg::rec_t wr_data,
    output logic            full,
    input  logic            rd_en,
    output logic            rd_valid,
    output udpck_pkg::rec_t rd_data
);
    import udpck_pkg::*;

    rec_t               mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;

    assign full = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data = mem[rd_ptr_reg];

    // Pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next = cnt_reg;
        if (wr_en)
        begin
            wr_ptr_next = wr_ptr_reg + Q_PTR_W'(1);
        end
        if (rd_en)
        begin
            rd_ptr_next = rd_ptr_reg + Q_PTR_W'(1);
        end
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + Q_CNT_W'(1);
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && full))
        else $error("write into full queue");

    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && !rd_valid))
        else $error("read from empty queue");

endmodule

// ----- src/udpck_back.sv -----
// Back end: builds IPv4 and UDP header sums over three stalling stages.
// The last stage is the result register. Depends on udpck_pkg.
module udpck_back (
    input  logic               clk,
    input  logic               rst_n,
    input  udpck_pkg::cfg_t    cfg,
    input  logic               q_valid,
    input  udpck_pkg::rec_t    q_data,
    output logic               q_rd,
    output logic               res_valid,
    output udpck_pkg::result_t res,
    input  logic               res_pop
);
    import udpck_pkg::*;

    stage1_t s1_reg, s1_next;
    stage2_t s2_reg, s2_next;
    result_t s3_reg, s3_next;
    logic    v1_reg, v2_reg, v3_reg;
    logic    rdy1, rdy2, rdy3;
    logic    ld1, ld2, ld3;
    logic [15:0] ip_len, udp_len;
    logic [16:0] ip_f1, udp_f1;
    logic [15:0] ip_f2, udp_f2, ip_ck, udp_ck;

    // Stall chain
    assign rdy3 = !v3_reg || res_pop;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign q_rd = q_valid && rdy1;
    assign ld1 = rdy1;
    assign ld2 = rdy2;
    assign ld3 = rdy3;

    // Stage 1: lengths and partial sums
    always_comb
    begin
        ip_len = IP_UDP_HDR_BYTES + {5'd0, q_data.count};
        udp_len = UDP_HDR_BYTES + {5'd0, q_data.count};
        s1_next.ip_len = ip_len;
        s1_next.udp_len = udp_len;
        s1_next.err = q_data.err;
        s1_next.ip_a = {1'b0, IP_FIXED_SUM} + {2'd0, ip_len}
                     + {2'd0, cfg.source_ip[31:16]} + {2'd0, cfg.source_ip[15:0]};
        s1_next.ip_b = {1'b0, cfg.dest_ip_addr[31:16]} + {1'b0, cfg.dest_ip_addr[15:0]};
        s1_next.udp_a = {2'd0, cfg.source_ip[31:16]} + {2'd0, cfg.source_ip[15:0]}
                      + {2'd0, cfg.dest_ip_addr[31:16]} + {2'd0, cfg.dest_ip_addr[15:0]};
        s1_next.udp_b = {3'd0, UDP_PROTO_WORD} + {3'd0, udp_len} + {3'd0, udp_len}
                      + {3'd0, cfg.source_port} + {3'd0, cfg.dest_port}
                      + {3'd0, q_data.payload_sum};
    end

    // Stage 2: complete the sums
    always_comb
    begin
        s2_next.ip_tot = {1'b0, s1_reg.ip_a} + {2'd0, s1_reg.ip_b};
        s2_next.udp_tot = {2'd0, s1_reg.udp_a} + {1'b0, s1_reg.udp_b};
        s2_next.ip_len = s1_reg.ip_len;
        s2_next.udp_len = s1_reg.udp_len;
        s2_next.err = s1_reg.err;
    end

    // Stage 3: fold carries, complement, zero sent as all ones; both checksums zero on error
    always_comb
    begin
        ip_f1 = {1'b0, s2_reg.ip_tot[15:0]} + {14'd0, s2_reg.ip_tot[18:16]};
        udp_f1 = {1'b0, s2_reg.udp_tot[15:0]} + {13'd0, s2_reg.udp_tot[19:16]};
        ip_f2 = ip_f1[15:0] + {15'd0, ip_f1[16]};
        udp_f2 = udp_f1[15:0] + {15'd0, udp_f1[16]};
        ip_ck = (~ip_f2 == '0) ? WORD_ONES : ~ip_f2;
        udp_ck = (~udp_f2 == '0) ? WORD_ONES : ~udp_f2;
        s3_next.ip_total_length = s2_reg.ip_len;
        s3_next.udp_length = s2_reg.udp_len;
        s3_next.length_error = s2_reg.err;
        s3_next.ip_header_checksum = s2_reg.err ? 16'd0 : ip_ck;
        s3_next.udp_checksum = s2_reg.err ? 16'd0 : udp_ck;
    end

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ld1)
            begin
                v1_reg <= q_valid;
            end
            if (ld2)
            begin
                v2_reg <= v1_reg;
            end
            if (ld3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            s1_reg <= s1_next;
        end
        if (ld2)
        begin
            s2_reg <= s2_next;
        end
        if (ld3)
        begin
            s3_reg <= s3_next;
        end
    end

    assign res_valid = v3_reg;
    assign res = s3_reg;

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && s3_reg.length_error) |->
            (s3_reg.ip_header_checksum == '0 && s3_reg.udp_checksum == '0))
        else $error("error result with nonzero checksum");

    a_ok_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !s3_reg.length_error) |->
            (s3_reg.ip_header_checksum != '0 && s3_reg.udp_checksum != '0))
        else $error("good result with zero checksum");

endmodule

// ----- src/udp_ipv4_checksum_fields.sv -----
// UDP/IPv4 length and checksum generator, top level: configuration registers and wiring.
// Depends on udpck_pkg, udpck_front, udpck_queue, udpck_back.
//
// Payload bytes are pushed one per cycle while full is low, with payload_last on the
// final byte of a datagram; each byte costs one 16-bit end-around-carry add in the
// front end, so the sustained rate is one byte per clock while full stays low.
// Finished datagrams wait in a four-entry queue and pass through a three-stage
// header-sum pipeline whose last stage is the result register; one result can be
// popped every cycle. full rises only when the queue holds four datagrams not yet
// taken by the pipeline. A payload that is odd in length or longer than MaxPayload
// gives length_error with both checksums zero. Configuration writes (cfg_ready is
// always high) should happen only while no datagram is in flight.
module udp_ipv4_checksum_fields #(
    parameter int MaxPayload = 1472
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [7:0]            payload_byte,
    input  logic                  payload_last,
    output logic                  empty,
    input  logic                  pop,
    output logic [15:0]           ip_total_length,
    output logic [15:0]           ip_header_checksum,
    output logic [15:0]           udp_length,
    output logic [15:0]           udp_checksum,
    output logic                  length_error,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  udpck_pkg::cfg_idx_t   cfg_index,
    input  logic [31:0]           cfg_data
);
    import udpck_pkg::*;

    logic [31:0] sip_reg, dip_reg;
    logic [15:0] sport_reg, dport_reg;
    cfg_t        cfg;
    logic        accept;
    logic        rec_valid;
    rec_t        rec;
    logic        q_full, q_rd, q_valid;
    rec_t        q_data;
    logic        res_valid;
    result_t     res;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sip_reg <= '0;
            dip_reg <= '0;
            sport_reg <= '0;
            dport_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SOURCE_IP:   sip_reg <= cfg_data;
                CFG_DEST_IP:     dip_reg <= cfg_data;
                CFG_SOURCE_PORT: sport_reg <= cfg_data[15:0];
                CFG_DEST_PORT:   dport_reg <= cfg_data[15:0];
                default:         sip_reg <= sip_reg;
            endcase
        end
    end

    assign cfg.source_ip = sip_reg;
    assign cfg.dest_ip_addr = dip_reg;
    assign cfg.source_port = sport_reg;
    assign cfg.dest_port = dport_reg;

    assign full = q_full;
    assign accept = push && !q_full;

    udpck_front #(
        .MaxPayload(MaxPayload)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .accept(accept),
        .payload_byte(payload_byte),
        .payload_last(payload_last),
        .rec_valid(rec_valid),
        .rec(rec)
    );

    udpck_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .wr_en(rec_valid),
        .wr_data(rec),
        .full(q_full),
        .rd_en(q_rd),
        .rd_valid(q_valid),
        .rd_data(q_data)
    );

    udpck_back u_back (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg),
        .q_valid(q_valid),
        .q_data(q_data),
        .q_rd(q_rd),
        .res_valid(res_valid),
        .res(res),
        .res_pop(pop)
    );

    // Result ports
    assign empty = !res_valid;
    assign ip_total_length = res.ip_total_length;
    assign ip_header_checksum = res.ip_header_checksum;
    assign udp_length = res.udp_length;
    assign udp_checksum = res.udp_checksum;
    assign length_error = res.length_error;

endmodule
